[hdl/dwc_pkg.sv]
// ----------------------------------------------------------------------------
// dwc_pkg
// shared types and constants for the deque with cursor
// ----------------------------------------------------------------------------
package dwc_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int DATA_BITS_DEF = 32;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 48;
    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 7;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_TO_START   = 3'd2,
        ACT_TO_END     = 3'd3,
        ACT_READ_NEXT  = 3'd4,
        ACT_READ_PREV  = 3'd5,
        ACT_PEEK       = 3'd6,
        ACT_CLEAR      = 3'd7
    } action_t;

    // controller to datapath
    typedef struct packed {
        logic accept;       // input item taken this cycle
        logic fill_direct;  // result stage loads a result with no store read
        logic fill_ram;     // result stage loads the store read data
        logic out_load;     // output register loads the result stage
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic rd_hit;       // offered item is a read or peek on a valid cursor
    } dp_status_t;

endpackage

[hdl/dwc_ram.sv]
// ----------------------------------------------------------------------------
// dwc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module dwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/dwc_ctrl.sv]
// ----------------------------------------------------------------------------
// dwc_ctrl
// handshake and sequencing state machine for the deque with cursor
// ----------------------------------------------------------------------------
module dwc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  dwc_pkg::dp_status_t status,
    output dwc_pkg::dp_cmd_t    cmd
);
    import dwc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        stage_valid_reg, stage_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_load;
    logic        stage_free;
    logic        accept;
    logic        fill_direct;
    logic        fill_ram;

    assign out_load   = stage_valid_reg && (!out_valid_reg || m_tready);
    assign stage_free = !stage_valid_reg || out_load;

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        accept     = 1'b0;
        fill_direct = 1'b0;
        fill_ram   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = stage_free;
                accept   = s_tvalid && stage_free;
                if (accept)
                begin
                    if (status.rd_hit)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        fill_direct = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                // store data is out of the ram this cycle
                fill_ram   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (fill_direct || fill_ram)
        begin
            stage_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign cmd.accept      = accept;
    assign cmd.fill_direct = fill_direct;
    assign cmd.fill_ram    = fill_ram;
    assign cmd.out_load    = out_load;

endmodule

[hdl/dwc_datapath.sv]
// ----------------------------------------------------------------------------
// dwc_datapath
// ring pointers, cursor, entry store and result registers
// ----------------------------------------------------------------------------
module dwc_datapath #(
    parameter int DEPTH     = 64,
    parameter int DATA_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dwc_pkg::dp_cmd_t                    cmd,
    output dwc_pkg::dp_status_t                 status,
    input  dwc_pkg::action_t                    in_action,
    input  logic [dwc_pkg::IN_TDATA_W-1:0]      in_data,
    output logic [dwc_pkg::OUT_TDATA_W-1:0]     out_tdata
);
    import dwc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic          cvalid_reg, cvalid_next;

    logic [CW-1:0] count_m1;
    logic [AW-1:0] tail_slot;
    logic          full;
    logic          is_read;
    logic          dropped;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [DATA_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [DATA_BITS-1:0] ram_rdata;

    logic [WORD_W-1:0]  stage_data_reg;
    logic               stage_rvalid_reg;
    logic [COUNT_W-1:0] stage_count_reg;
    logic               stage_dropped_reg;
    logic [OUT_TDATA_W-1:0] out_tdata_reg;

    function automatic logic [AW-1:0] slot_fwd(input logic [AW-1:0] s);
        return (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_back(input logic [AW-1:0] s);
        return (s == '0) ? AW'(DEPTH - 1) : s - AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] s,
                                               input logic [CW-1:0] n);
        logic [SW-1:0] t;
        t = SW'(s) + SW'(n);
        if (t >= SW'(DEPTH))
        begin
            t = t - SW'(DEPTH);
        end
        return t[AW-1:0];
    endfunction

    assign count_m1  = count_reg - CW'(1);
    assign tail_slot = slot_add(head_reg, count_m1);
    assign full      = count_reg >= CW'(DEPTH);
    assign is_read   = (in_action == ACT_READ_NEXT) || (in_action == ACT_READ_PREV)
                    || (in_action == ACT_PEEK);
    assign status.rd_hit = is_read && cvalid_reg;
    assign ram_wdata = DATA_BITS'(in_data);
    assign ram_re    = cmd.accept && status.rd_hit;

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        cvalid_next = cvalid_reg;
        ram_we      = 1'b0;
        ram_waddr   = slot_add(head_reg, count_reg);
        dropped     = 1'b0;
        if (cmd.accept)
        begin
            case (in_action)
                ACT_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        dropped = 1'b1;
                    end
                    else
                    begin
                        head_next  = slot_back(head_reg);
                        ram_waddr  = slot_back(head_reg);
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                ACT_PUSH_BACK:
                begin
                    if (full)
                    begin
                        dropped = 1'b1;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                ACT_TO_START:
                begin
                    cvalid_next = count_reg != '0;
                    cur_next    = (count_reg != '0) ? head_reg : '0;
                end
                ACT_TO_END:
                begin
                    cvalid_next = count_reg != '0;
                    cur_next    = (count_reg != '0) ? tail_slot : '0;
                end
                ACT_READ_NEXT:
                begin
                    if (cvalid_reg)
                    begin
                        if (cur_reg == tail_slot)
                        begin
                            cvalid_next = 1'b0;
                        end
                        else
                        begin
                            cur_next = slot_fwd(cur_reg);
                        end
                    end
                end
                ACT_READ_PREV:
                begin
                    if (cvalid_reg)
                    begin
                        if (cur_reg == head_reg)
                        begin
                            cvalid_next = 1'b0;
                        end
                        else
                        begin
                            cur_next = slot_back(cur_reg);
                        end
                    end
                end
                ACT_PEEK:
                begin
                    // cursor does not move
                end
                ACT_CLEAR:
                begin
                    head_next   = '0;
                    count_next  = '0;
                    cur_next    = '0;
                    cvalid_next = 1'b0;
                end
                default:
                begin
                    head_next = head_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            cur_reg    <= '0;
            cvalid_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            cur_reg    <= cur_next;
            cvalid_reg <= cvalid_next;
        end
    end

    dwc_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cur_reg),
        .rdata (ram_rdata)
    );

    // result stage and output register, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            stage_rvalid_reg  <= status.rd_hit;
            stage_count_reg   <= COUNT_W'(count_next);
            stage_dropped_reg <= dropped;
        end
        if (cmd.fill_direct)
        begin
            stage_data_reg <= '0;
        end
        else if (cmd.fill_ram)
        begin
            stage_data_reg <= WORD_W'(ram_rdata);
        end
        if (cmd.out_load)
        begin
            out_tdata_reg <= {{(OUT_TDATA_W - WORD_W - COUNT_W - 2){1'b0}},
                              stage_dropped_reg, stage_count_reg,
                              stage_rvalid_reg, stage_data_reg};
        end
    end

    assign out_tdata = out_tdata_reg;

endmodule

[hdl/deque_with_cursor.sv]
// ----------------------------------------------------------------------------
// deque_with_cursor
// bounded double-ended queue in a ring store with one movable cursor
// ----------------------------------------------------------------------------
// path: accepted items pass the result stage and the output register; a read
//   or peek on a valid cursor first waits for the registered ram read
// throughput: 1 item per cycle while the output is not stalled; a read or peek
//   that hits blocks the next item: the entry store has one registered read port
// reset: rst_n asynchronous active low, clears pointers, count, cursor and
//   handshake state; entry store contents stay undefined, no clearing pass
// ----------------------------------------------------------------------------
module deque_with_cursor #(
    parameter int DEPTH     = dwc_pkg::DEPTH_DEF,
    parameter int DATA_BITS = dwc_pkg::DATA_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input item channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dwc_pkg::IN_TDATA_W-1:0]      s_tdata,  // [31:0] item_data
    input  logic [dwc_pkg::IN_TUSER_W-1:0]      s_tuser,  // [2:0] action
    // result item channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] read_data, [32] read_valid, [39:33] entry_count,
    // [40] push_dropped, [47:41] zero
    output logic [dwc_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import dwc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    action_t    in_action;

    // action code arrives on tuser
    assign in_action = action_t'(s_tuser);

    // controller: handshakes, ram read wait, result stage and output valid flags
    dwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: head, count, cursor, entry store and result payload
    dwc_datapath #(
        .DEPTH     (DEPTH),
        .DATA_BITS (DATA_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_action (in_action),
        .in_data   (s_tdata),
        .out_tdata (m_tdata)
    );

endmodule

[hdl/dwc_checker.sv]
// ----------------------------------------------------------------------------
// dwc_checker
// port level checks for the deque with cursor, bound to the top level
// ----------------------------------------------------------------------------
module dwc_checker #(
    parameter int DEPTH = 64
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a read hit never reports a dropped push
    a_read_not_drop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[32] && m_tdata[40]))
        else $error("read_valid and push_dropped both set");

    // data is zero when no entry was read
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == 32'd0)
        else $error("read_data nonzero without read_valid");

    // count never exceeds the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (DEPTH > 127) || (m_tdata[39:33] <= 7'(DEPTH)))
        else $error("entry_count above depth");

endmodule

bind deque_with_cursor dwc_checker #(.DEPTH(DEPTH)) u_dwc_checker (.*);

[sim/deque_with_cursor_tb.sv]
// ----------------------------------------------------------------------------
// deque_with_cursor_tb
// self-checking bench for the deque with cursor
// ----------------------------------------------------------------------------
// a shadow deque tracks ring slots, entry count and cursor for every accepted
// item and queues the reply it should cause; replies leaving the block are
// compared field by field in arrival order. a directed opening covers empty
// store, wrap of the front pointer, cursor walks off both ends and clear,
// then random phases fill the store to its limit, walk the cursor and mix
// all actions while both sides stall at random outside one steady stretch
// ----------------------------------------------------------------------------

class deque_shadow;

    localparam int SLOTS  = dwc_pkg::DEPTH_DEF;
    localparam int SLOT_W = $clog2(dwc_pkg::DEPTH_DEF);

    typedef struct packed {
        logic [dwc_pkg::WORD_W-1:0]  read_data;
        logic                        read_valid;
        logic [dwc_pkg::COUNT_W-1:0] entry_count;
        logic                        push_dropped;
    } reply_t;

    logic [dwc_pkg::WORD_W-1:0]  words [SLOTS];
    logic [SLOT_W-1:0]           head;
    logic [dwc_pkg::COUNT_W-1:0] count;
    logic [SLOT_W-1:0]           cursor;
    logic                        cursor_on;

    reply_t replies_due[$];
    int     mismatches;
    int     replies_checked;
    int     refused_pushes;
    int     hit_reads;
    int     peak_count;

    function new();
        head            = '0;
        count           = '0;
        cursor          = '0;
        cursor_on       = 1'b0;
        mismatches      = 0;
        replies_checked = 0;
        refused_pushes  = 0;
        hit_reads       = 0;
        peak_count      = 0;
    endfunction

    // mirror one accepted action and queue the reply it causes
    function void take_action(dwc_pkg::action_t act, logic [dwc_pkg::WORD_W-1:0] word);
        reply_t            r;
        logic [SLOT_W-1:0] tail;
        r    = '0;
        tail = head + SLOT_W'(count - 1'b1);
        case (act)
            dwc_pkg::ACT_PUSH_FRONT, dwc_pkg::ACT_PUSH_BACK:
            begin
                if (count >= SLOTS)
                begin
                    r.push_dropped = 1'b1;
                    refused_pushes++;
                end
                else if (act == dwc_pkg::ACT_PUSH_FRONT)
                begin
                    head        = head - 1'b1;
                    words[head] = word;
                    count++;
                end
                else
                begin
                    words[head + SLOT_W'(count)] = word;
                    count++;
                end
            end
            dwc_pkg::ACT_TO_START:
            begin
                cursor_on = (count != 0);
                cursor    = cursor_on ? head : '0;
            end
            dwc_pkg::ACT_TO_END:
            begin
                cursor_on = (count != 0);
                cursor    = cursor_on ? tail : '0;
            end
            dwc_pkg::ACT_READ_NEXT, dwc_pkg::ACT_READ_PREV, dwc_pkg::ACT_PEEK:
            begin
                if (cursor_on)
                begin
                    r.read_data  = words[cursor];
                    r.read_valid = 1'b1;
                    hit_reads++;
                    if (act == dwc_pkg::ACT_READ_NEXT)
                    begin
                        if (cursor == tail)
                            cursor_on = 1'b0;
                        else
                            cursor = cursor + 1'b1;
                    end
                    else if (act == dwc_pkg::ACT_READ_PREV)
                    begin
                        if (cursor == head)
                            cursor_on = 1'b0;
                        else
                            cursor = cursor - 1'b1;
                    end
                end
            end
            default:
            begin
                // clear keeps the stored words
                head      = '0;
                count     = '0;
                cursor    = '0;
                cursor_on = 1'b0;
            end
        endcase
        r.entry_count = count;
        if (count > peak_count)
            peak_count = count;
        replies_due.push_back(r);
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch on %s: expected %0h got %0h", $time, what, want, got);
    endfunction

    // compare one reply against the oldest one queued
    function void check_reply(logic [dwc_pkg::OUT_TDATA_W-1:0] got);
        reply_t want;
        if (replies_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] reply %0h arrived with none queued", $time, got);
            return;
        end
        want = replies_due.pop_front();
        replies_checked++;
        if (got[31:0] !== want.read_data)
            flag("read_data", want.read_data, got[31:0]);
        if (got[32] !== want.read_valid)
            flag("read_valid", want.read_valid, got[32]);
        if (got[39:33] !== want.entry_count)
            flag("entry_count", want.entry_count, got[39:33]);
        if (got[40] !== want.push_dropped)
            flag("push_dropped", want.push_dropped, got[40]);
        if (got[47:41] !== '0)
            flag("pad bits", 0, got[47:41]);
    endfunction

    function int outstanding();
        return replies_due.size();
    endfunction

endclass

module deque_with_cursor_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dwc_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 11;

    // random phase flavors
    localparam int PHASE_FILL = 0;
    localparam int PHASE_WALK = 1;
    localparam int PHASE_MIX  = 2;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // [31:0] item_data
    logic [IN_TUSER_W-1:0]  s_tuser;   // [2:0] action
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [31:0] read_data, [32] read_valid,
                                       // [39:33] entry_count, [40] push_dropped

    deque_shadow shadow;
    int          cycles;
    int          items_sent;
    bit          steady;   // when set neither side idles

    deque_with_cursor dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (steady)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // both handshakes seen with pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                shadow.check_reply(m_tdata);
            if (s_tvalid && s_tready)
                shadow.take_action(action_t'(s_tuser), s_tdata);
        end
    end

    // offer one item, maybe after a random gap, and hold it until taken
    task automatic send_item(input action_t act, input logic [WORD_W-1:0] word);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // action mix depends on the phase: fill drives toward a full store,
    // walk moves the cursor across whatever is stored, mix picks any action
    function automatic action_t pick_action(input int phase);
        int roll;
        roll = $urandom_range(0, 99);
        case (phase)
            PHASE_FILL:
                if (roll < 85)
                    return (roll & 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
                else
                    return action_t'($urandom_range(ACT_TO_START, ACT_PEEK));
            PHASE_WALK:
                if (roll < 8)
                    return ACT_TO_START;
                else if (roll < 16)
                    return ACT_TO_END;
                else if (roll < 48)
                    return ACT_READ_NEXT;
                else if (roll < 76)
                    return ACT_READ_PREV;
                else if (roll < 86)
                    return ACT_PEEK;
                else if (roll < 97)
                    return (roll & 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
                else
                    return ACT_CLEAR;
            default:
                return action_t'($urandom_range(ACT_PUSH_FRONT, ACT_CLEAR));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int phase;
        int phase_left;
        int roll;

        shadow     = new();
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = ACT_PEEK;
        m_tready   = 1'b0;
        cycles     = 0;
        items_sent = 0;
        steady     = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, front wrap, walks off both ends, clear
        send_item(ACT_CLEAR,      32'h1234_5678);
        send_item(ACT_PEEK,       '0);          // cursor points nowhere
        send_item(ACT_TO_START,   '0);          // empty store keeps it invalid
        send_item(ACT_TO_END,     '0);
        send_item(ACT_READ_NEXT,  '0);
        send_item(ACT_PUSH_BACK,  32'h0000_0000);
        send_item(ACT_PUSH_FRONT, 32'hffff_ffff);  // head wraps to the top slot
        send_item(ACT_PUSH_BACK,  32'ha5a5_a5a5);
        send_item(ACT_TO_START,   '0);
        send_item(ACT_READ_NEXT,  '0);
        send_item(ACT_PUSH_FRONT, 32'h5a5a_5a5a);  // cursor stays on its entry
        send_item(ACT_READ_NEXT,  '0);
        send_item(ACT_READ_NEXT,  '0);          // steps past the last entry
        send_item(ACT_READ_NEXT,  '0);
        send_item(ACT_PUSH_BACK,  32'h8000_0001);  // invalid cursor stays invalid
        send_item(ACT_PEEK,       '0);
        send_item(ACT_TO_END,     '0);
        send_item(ACT_READ_PREV,  '0);
        send_item(ACT_READ_PREV,  '0);
        send_item(ACT_READ_PREV,  '0);
        send_item(ACT_READ_PREV,  '0);
        send_item(ACT_READ_PREV,  '0);          // steps past the first entry
        send_item(ACT_PEEK,       '0);
        send_item(ACT_CLEAR,      '0);
        send_item(ACT_TO_END,     '0);          // cleared store, cursor invalid

        // random phases
        phase_left = 0;
        phase      = PHASE_MIX;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 500 && n < 800);
            if (phase_left == 0)
            begin
                roll       = $urandom_range(0, 99);
                phase      = (roll < 35) ? PHASE_FILL : (roll < 80) ? PHASE_WALK : PHASE_MIX;
                phase_left = $urandom_range(40, 120);
            end
            phase_left--;
            send_item(pick_action(phase), pick_word());
        end
        s_tvalid <= 1'b0;
        steady   = 1'b0;

        // drain, then give a stray reply time to show up
        while (shadow.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d items sent, %0d replies checked, %0d valid reads",
                 items_sent, shadow.replies_checked, shadow.hit_reads);
        $display("peak fill %0d entries, %0d pushes refused on a full store, %0d mismatches",
                 shadow.peak_count, shadow.refused_pushes, shadow.mismatches);
        if (shadow.mismatches == 0 && shadow.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
